// ===== sv/cse_pkg.sv =====
// shared constants, result type and packing function of the cosine similarity engine
`default_nettype none
package cse_pkg;

    localparam int OUT_FRAC = 15;
    localparam int OUT_W    = 16;
    localparam int QMAG_W   = OUT_W + 1;

    typedef struct packed {
        logic [OUT_W-1:0] similarity;
        logic             saturated;
    } cse_result_t;

    // magnitude in Q1.15 units plus an overflow flag, sign applied afterwards
    function automatic cse_result_t cse_pack(input logic neg, input logic [QMAG_W-1:0] q,
                                             input logic big);
        cse_result_t      res;
        logic [QMAG_W-1:0] m;
        logic             sat;
        m   = q;
        sat = 1'b0;
        if (!neg && (big || q > QMAG_W'(32767))) begin
            m   = QMAG_W'(32767);
            sat = 1'b1;
        end
        if (neg && (big || q > QMAG_W'(32768))) begin
            m   = QMAG_W'(32768);
            sat = 1'b1;
        end
        res.similarity = neg ? (OUT_W'(0) - m[OUT_W-1:0]) : m[OUT_W-1:0];
        res.saturated  = sat;
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== sv/cse_front.sv =====
// front end: accepts element pairs and keeps the saturating accumulators
`default_nettype none
module cse_front
    import cse_pkg::*;
#(
    parameter int ELEM_WIDTH = 16,
    parameter int ACC_WIDTH  = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic signed [ELEM_WIDTH-1:0]  elem_a,
    input  wire logic signed [ELEM_WIDTH-1:0]  elem_b,
    input  wire logic                          last_element,
    input  wire logic                          mode,
    output logic                               push,
    output logic [3*ACC_WIDTH:0]               push_data
);
    localparam int PW = 2 * ELEM_WIDTH;
    localparam int SW = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;

    logic signed [ACC_WIDTH-1:0] dot_reg, na_reg, nb_reg;
    logic signed [ACC_WIDTH-1:0] dot_next, na_next, nb_next;

    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] acc, input logic signed [PW-1:0] p);
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] mx;
        logic signed [SW-1:0] mn;
        mx = (SW'(1) <<< (ACC_WIDTH - 1)) - SW'(1);
        mn = -mx - SW'(1);
        s  = SW'(acc) + SW'(p);
        if (s > mx) s = mx;
        if (s < mn) s = mn;
        return s[ACC_WIDTH-1:0];
    endfunction

    always_comb
    begin
        dot_next  = sat_add(dot_reg, elem_a * elem_b);
        na_next   = sat_add(na_reg, elem_a * elem_a);
        nb_next   = sat_add(nb_reg, elem_b * elem_b);
        push      = accept && last_element;
        push_data = {mode, dot_next, na_next, nb_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end
        else if (accept)
        begin
            if (last_element)
            begin
                dot_reg <= '0;
                na_reg  <= '0;
                nb_reg  <= '0;
            end
            else
            begin
                dot_reg <= dot_next;
                na_reg  <= na_next;
                nb_reg  <= nb_next;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/cse_queue.sv =====
// two-entry queue of finished sums between front and back
`default_nettype none
module cse_queue
    import cse_pkg::*;
#(
    parameter int W = 145
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic [W-1:0]      head,
    output logic              empty,
    output logic              full
);
    logic [W-1:0] mem_reg [2];
    logic         wptr_reg, rptr_reg;
    logic [1:0]   cnt_reg;

    assign head  = mem_reg[rptr_reg];
    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== sv/cse_back.sv =====
// back end: iterative multiply, square root, division and rounding; raw dot mode only rounds
`default_nettype none
module cse_back
    import cse_pkg::*;
#(
    parameter int ELEM_WIDTH = 16,
    parameter int ACC_WIDTH  = 48
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [3*ACC_WIDTH:0]  head,
    input  wire logic                  empty,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [OUT_W-1:0]           similarity,
    output logic                       saturated
);
    localparam int A    = ACC_WIDTH;
    localparam int NW   = A - 1;
    localparam int PRW  = 2 * NW;
    localparam int RW   = NW + 2;
    localparam int DW   = NW + 1;
    localparam int CW   = $clog2(A) + 1;
    localparam int PF   = 2 * (ELEM_WIDTH / 2);
    localparam int SH   = (PF >= OUT_FRAC) ? PF - OUT_FRAC : 0;
    localparam int SHM1 = (SH > 0) ? SH - 1 : 0;
    localparam int LS   = (PF < OUT_FRAC) ? OUT_FRAC - PF : 0;
    localparam int QW   = A + 16;
    localparam longint unsigned EPS_RAW = ((64'd1 << PF) + 64'd50000) / 64'd100000;
    localparam longint unsigned EPS     = (EPS_RAW == 0) ? 64'd1 : EPS_RAW;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_SQRT, S_DIV, S_FRAC, S_OUT} state_t;

    state_t            state_reg;
    logic [CW-1:0]     cnt_reg;
    logic              neg_reg;
    logic [A-1:0]      mag_reg;
    logic [NW-1:0]     nb_reg;
    logic [PRW-1:0]    mcand_reg, prod_reg;
    logic [RW-1:0]     rem_reg;
    logic [NW-1:0]     root_reg;
    logic [DW-1:0]     den_reg, r_reg;
    logic [QMAG_W-1:0] q_reg;
    logic              big_reg;
    cse_result_t       res_reg;

    logic              h_mode;
    logic [A-1:0]      h_dot, h_na, h_nb;
    logic [A-1:0]      h_mag;
    logic [QW-1:0]     qpre;
    logic [RW-1:0]     rem_sh, trial;
    logic [A+1:0]      mag_w, den_w;
    logic [DW:0]       r2;

    assign {h_mode, h_dot, h_na, h_nb} = head;
    assign pop        = (state_reg == S_IDLE) && !empty;
    assign out_valid  = (state_reg == S_OUT);
    assign similarity = res_reg.similarity;
    assign saturated  = res_reg.saturated;

    always_comb
    begin
        h_mag = h_dot[A-1] ? (A'(0) - h_dot) : h_dot;
        if (PF >= OUT_FRAC)
        begin
            if (SH == 0) qpre = QW'(h_mag);
            else qpre = QW'(h_mag >> SH) + QW'((h_mag >> SHM1) & A'(1));
        end
        else
            qpre = QW'(h_mag) << LS;
        rem_sh = {rem_reg[RW-3:0], prod_reg[PRW-1:PRW-2]};
        trial  = {root_reg, 2'b01};
        mag_w  = (A+2)'(mag_reg);
        den_w  = (A+2)'(den_reg);
        r2     = {r_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (!empty)
                    begin
                        neg_reg <= h_dot[A-1];
                        mag_reg <= h_mag;
                        if (h_mode)
                        begin
                            res_reg   <= cse_pack(h_dot[A-1], qpre[QMAG_W-1:0],
                                                  |(qpre >> QMAG_W));
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            mcand_reg <= PRW'(h_na[A-1] ? NW'(0) : h_na[NW-1:0]);
                            nb_reg    <= h_nb[A-1] ? NW'(0) : h_nb[NW-1:0];
                            prod_reg  <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    // shift-add, one multiplier bit per cycle
                    if (nb_reg[0]) prod_reg <= prod_reg + mcand_reg;
                    mcand_reg <= mcand_reg << 1;
                    nb_reg    <= nb_reg >> 1;
                    cnt_reg   <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(NW - 1))
                    begin
                        cnt_reg   <= '0;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    // restoring square root, one root bit per cycle
                    prod_reg <= prod_reg << 2;
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[NW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(NW - 1)) state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    den_reg <= DW'(root_reg) + DW'(EPS);
                    state_reg <= S_FRAC;
                    cnt_reg   <= '0;
                    big_reg   <= 1'b0;
                    if (mag_w >= ((A+2)'(DW'(root_reg) + DW'(EPS)) << 1))
                    begin
                        big_reg <= 1'b1;
                        r_reg   <= '0;
                        q_reg   <= '0;
                    end
                    else if (mag_w >= (A+2)'(DW'(root_reg) + DW'(EPS)))
                    begin
                        r_reg <= DW'(mag_w - (A+2)'(DW'(root_reg) + DW'(EPS)));
                        q_reg <= QMAG_W'(1);
                    end
                    else
                    begin
                        r_reg <= DW'(mag_reg);
                        q_reg <= '0;
                    end
                end
                S_FRAC:
                begin
                    if (r2 >= (DW+1)'(den_reg))
                    begin
                        r_reg <= DW'(r2 - (DW+1)'(den_reg));
                        q_reg <= {q_reg[QMAG_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= DW'(r2);
                        q_reg <= {q_reg[QMAG_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(OUT_FRAC))
                    begin
                        res_reg   <= cse_pack(neg_reg,
                                              (QMAG_W'(r2 >= (DW+1)'(den_reg)) +
                                               (q_reg >> 0)), big_reg);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/cosine_similarity_engine.sv =====
// top level of the streaming cosine similarity engine
// result path: the sums of a vector's last pair enter the queue; the back end then multiplies,
//   takes the square root and divides in cosine mode, or only rounds the dot in raw dot mode
// flow: one element pair per cycle while in_stall is low; the back end starts a vector only after
//   the last has left, in cosine mode after the shift-add multiplier, bit-serial root and divider
// reset: asynchronous, clears accumulators, queue, back-end state and the mode register
`default_nettype none
module cosine_similarity_engine
    import cse_pkg::*;
#(
    parameter int ELEM_WIDTH = 16,
    parameter int ACC_WIDTH  = 48
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_wdata,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [ELEM_WIDTH-1:0] elem_a,
    input  wire logic signed [ELEM_WIDTH-1:0] elem_b,
    input  wire logic                         last_element,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [OUT_W-1:0]           similarity,
    output logic                              saturated
);
    localparam int QW = 3 * ACC_WIDTH + 1;

    logic          mode_reg;
    logic          accept, push, pop, empty, full;
    logic [QW-1:0] push_data, head;
    logic [OUT_W-1:0] sim_u;

    // mode register; the user must write it only while the block is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) mode_reg <= 1'b0;
        else if (cfg_we) mode_reg <= cfg_wdata;
    end

    // hold off items only while both queue slots hold finished vectors
    assign in_stall = full;
    assign accept   = in_valid && !in_stall;

    // front: per-item products and saturating sums
    cse_front #(.ELEM_WIDTH(ELEM_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .accept(accept), .elem_a(elem_a), .elem_b(elem_b),
        .last_element(last_element), .mode(mode_reg), .push(push), .push_data(push_data)
    );

    // queue of sums so the front keeps streaming while the back divides
    cse_queue #(.W(QW)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .pop(pop),
        .head(head), .empty(empty), .full(full)
    );

    // back: iterative normalization and output register
    cse_back #(.ELEM_WIDTH(ELEM_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .empty(empty), .pop(pop),
        .out_valid(out_valid), .out_stall(out_stall), .similarity(sim_u),
        .saturated(saturated)
    );

    assign similarity = signed'(sim_u);
endmodule
`default_nettype wire

// ===== sv/cse_checker.sv =====
// port-level checker for the cosine similarity engine and its bind
`default_nettype none
module cse_port_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] similarity,
    input wire logic        saturated
);
    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(similarity) && $stable(saturated))
        else $error("stalled result changed");

    // a clipped result sits at a range limit
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> similarity == 16'h7fff || similarity == 16'h8000)
        else $error("saturated result off the limits");

    // nothing comes out in reset
    a_rst: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result during reset");
endmodule

bind cosine_similarity_engine cse_port_checker u_cse_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .similarity(similarity), .saturated(saturated)
);
`default_nettype wire

// ===== tb/sv/cse_checker.sv =====
// checker of the cosine similarity engine: predicts each vector result and compares
`timescale 1ns / 100ps
module cse_checker
    import cse_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic signed [15:0] elem_a,
    input  wire logic signed [15:0] elem_b,
    input  wire logic               last_element,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic signed [15:0] similarity,
    input  wire logic               saturated,
    output int                      fail_count,
    output int                      pending
);

    localparam longint SUM_MAX = (64'sd1 <<< 47) - 1;
    localparam longint SUM_MIN = -(64'sd1 <<< 47);

    longint      dot_sum, norm_a_sum, norm_b_sum;
    logic        raw_dot_mode;
    cse_result_t expected_results[$];

    function automatic longint clip_add(input longint acc, input longint p);
        longint s;
        s = acc + p;
        if (s > SUM_MAX) return SUM_MAX;
        if (s < SUM_MIN) return SUM_MIN;
        return s;
    endfunction

    function automatic bit [63:0] root_of(input bit [127:0] n);
        bit [63:0]  r;
        bit [63:0]  c;
        bit [127:0] sq;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            c  = r | (64'd1 << i);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= n) r = c;
        end
        return r;
    endfunction

    function automatic cse_result_t similarity_of(input longint dot, input longint na,
                                                  input longint nb, input logic raw);
        cse_result_t res;
        logic        neg;
        bit [63:0]   mag, q, den, ip, rem, q16;
        bit [127:0]  prod;
        neg = dot < 0;
        mag = neg ? 64'(-dot) : 64'(dot);
        if (raw) begin
            // 16 fraction bits down to 15, round half away from zero
            q = (mag >> 1) + (mag & 64'd1);
        end else begin
            prod = {64'd0, 64'(na < 0 ? 0 : na)} * {64'd0, 64'(nb < 0 ? 0 : nb)};
            den  = root_of(prod) + 64'd1;   // epsilon is one lsb
            ip   = mag / den;
            rem  = mag % den;
            if (ip >= 2) begin
                q = '1;
            end else begin
                q16 = ip;
                for (int i = 0; i < 16; i++) begin
                    q16 = q16 << 1;
                    if (rem >= den - rem) begin
                        q16 = q16 | 64'd1;
                        rem = rem - (den - rem);
                    end else begin
                        rem = rem + rem;
                    end
                end
                q = (q16 >> 1) + (q16 & 64'd1);
            end
        end
        res.saturated = 1'b0;
        if (!neg && q > 64'd32767) begin
            q = 64'd32767;
            res.saturated = 1'b1;
        end
        if (neg && q > 64'd32768) begin
            q = 64'd32768;
            res.saturated = 1'b1;
        end
        res.similarity = neg ? 16'(17'h10000 - q[16:0]) : q[15:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        cse_result_t got;
        cse_result_t want;
        longint      a, b;
        int          errs;
        if (!rst_n) begin
            dot_sum      <= 0;
            norm_a_sum   <= 0;
            norm_b_sum   <= 0;
            raw_dot_mode <= 1'b0;
            fail_count   <= 0;
            pending      <= 0;
            expected_results.delete();
        end else begin
            errs = 0;
            if (cfg_we) raw_dot_mode <= cfg_wdata;
            if (in_valid && !in_stall) begin
                a = elem_a;
                b = elem_b;
                if (last_element) begin
                    expected_results.push_back(similarity_of(clip_add(dot_sum, a * b),
                        clip_add(norm_a_sum, a * a), clip_add(norm_b_sum, b * b),
                        raw_dot_mode));
                    dot_sum    <= 0;
                    norm_a_sum <= 0;
                    norm_b_sum <= 0;
                end else begin
                    dot_sum    <= clip_add(dot_sum, a * b);
                    norm_a_sum <= clip_add(norm_a_sum, a * a);
                    norm_b_sum <= clip_add(norm_b_sum, b * b);
                end
            end
            if (out_valid && !out_stall) begin
                got.similarity = similarity;
                got.saturated  = saturated;
                if (expected_results.size() == 0) begin
                    $error("result with no vector waiting: similarity %0d", similarity);
                    errs = errs + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.similarity !== want.similarity) begin
                        $error("similarity: expected %0d, actual %0d",
                               $signed(want.similarity), $signed(got.similarity));
                        errs = errs + 1;
                    end
                    if (got.saturated !== want.saturated) begin
                        $error("saturated: expected %0b, actual %0b",
                               want.saturated, got.saturated);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= expected_results.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the cosine similarity engine testbench: stimulus, idling and verdict
`timescale 1ns / 100ps
module testbench;
    import cse_pkg::*;

    // longest correct pause after the last pair of a vector
    localparam int DRAIN_CYCLES = 2 * 48 + 30;
    localparam int CYCLE_LIMIT  = 2000000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    logic               last_element;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] similarity;
    logic               saturated;
    int                 fail_count;
    int                 pending;
    int                 cycle_count;
    int                 item_count;
    bit                 idling_on;     // cleared for the last part of the run
    int                 stall_left;

    cosine_similarity_engine DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .elem_a      (elem_a),
        .elem_b      (elem_b),
        .last_element(last_element),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .similarity  (similarity),
        .saturated   (saturated)
    );

    cse_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .elem_a      (elem_a),
        .elem_b      (elem_b),
        .last_element(last_element),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .similarity  (similarity),
        .saturated   (saturated),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // receiver back-pressure in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall  = 1'b1;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            out_stall  = 1'b1;
        end
        else
            out_stall = 1'b0;
    end

    // one element pair; valid stays high afterwards so back-to-back items need no dip
    task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic is_last);
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            gap      = $urandom_range(1, 7);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        elem_a       = a;
        elem_b       = b;
        last_element = is_last;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        item_count = item_count + 1;
    endtask

    // wait for every vector result, then the back end's full latency
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_mode(input logic raw);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = raw;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'($signed($urandom_range(0, 1023)) - 512);
            3:       return 16'($signed($urandom_range(0, 8191)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    // a vector pair of random length with a few shaped relations between a and b
    task automatic send_vector(input int len);
        int                 kind;
        logic signed [15:0] a;
        logic signed [15:0] b;
        kind = $urandom_range(0, 5);
        for (int i = 0; i < len; i++)
        begin
            a = rand_elem();
            case (kind)
                0:       b = a;                         // parallel
                1:       b = (a == 16'sh8000) ? 16'sh7fff : -a;  // opposite
                2:       b = 16'(a >>> 1);
                default: b = rand_elem();
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    task automatic random_vectors(input int goal);
        int target;
        target = item_count + goal;
        while (item_count < target)
            send_vector(($urandom_range(0, 9) == 0) ? $urandom_range(17, 60)
                                                    : $urandom_range(1, 12));
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        in_valid     = 1'b0;
        elem_a       = '0;
        elem_b       = '0;
        last_element = 1'b0;
        out_stall    = 1'b0;
        stall_left   = 0;
        cycle_count  = 0;
        item_count   = 0;
        idling_on    = 1'b1;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, cosine mode
        send_pair(16'sh0000, 16'sh0000, 1'b1);          // zero vectors
        send_pair(16'sh0000, 16'sh1234, 1'b0);          // one zero vector
        send_pair(16'sh0000, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);          // extremes, parallel
        send_pair(16'sh7fff, 16'sh8000, 1'b1);          // extremes, opposite
        send_pair(16'sh0100, 16'sh0100, 1'b0);
        send_pair(16'sh0100, 16'shff00, 1'b1);          // orthogonal
        send_pair(16'sh0001, 16'shffff, 1'b1);          // tiny negative dot
        send_pair(16'sh0003, 16'sh0004, 1'b0);
        send_pair(16'sh0004, 16'shfffd, 1'b1);
        send_pair(16'sh7fff, 16'sh7fff, 1'b0);
        send_pair(16'sh5555, 16'shaaaa, 1'b1);

        // directed, raw dot mode
        set_mode(1'b1);
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        send_pair(16'sh0001, 16'sh0001, 1'b1);          // half lsb rounds away
        send_pair(16'shffff, 16'sh0001, 1'b1);
        send_pair(16'sh00b5, 16'sh00b5, 1'b1);          // near one half
        send_pair(16'sh0100, 16'shff00, 1'b1);          // exactly minus one
        send_pair(16'sh0100, 16'sh0100, 1'b1);          // plus one clips
        send_pair(16'sh8000, 16'sh7fff, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);

        // random vectors across mode changes, quiet at the end
        item_count = 0;
        set_mode(1'b0);
        random_vectors(350);
        set_mode(1'b1);
        random_vectors(350);
        set_mode(1'b0);
        random_vectors(200);
        idling_on = 1'b0;
        random_vectors(200);

        drain();
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cse_pkg.sv
sv/cse_front.sv
sv/cse_queue.sv
sv/cse_back.sv
sv/cosine_similarity_engine.sv
sv/cse_checker.sv
tb/sv/cse_checker.sv
tb/sv/testbench.sv
